[design/pnbg_pkg.sv]
// ----------------------------------------------------------------------------
// pnbg_pkg
// Types, constants and helpers for the planar n-body gravity step unit.
// ----------------------------------------------------------------------------
package pnbg_pkg;

  localparam int unsigned MaxBodiesDef = 64;

  localparam logic [6:0]  ActiveCountRst = 7'd0;
  localparam logic [23:0] GravConstRst   = 24'd45875;
  localparam logic [15:0] SofteningRst   = 16'd300;

  localparam logic [47:0] AccCap = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] DvCap  = 34'h2_0000_0000;

  typedef enum logic [1:0] {
    CFG_ACTIVE_COUNT = 2'd0,
    CFG_GRAV_CONST   = 2'd1,
    CFG_SOFTENING_SQ = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LAT,
    ST_PAIR_RD,
    ST_PAIR_LAT,
    ST_SQR,
    ST_M2,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_DIVA,
    ST_DV_MUL,
    ST_DV_CAP,
    ST_U_MUL,
    ST_APPLY,
    ST_ROW_WR,
    ST_ADV_RD,
    ST_ADV_LAT,
    ST_ADV_MUL,
    ST_ADV_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [23:0] mass;
  } body_t;

  // v +/- c, clipped to the signed 32-bit range
  function automatic logic signed [31:0] sat_add(logic signed [31:0] v, logic [33:0] c,
                                                 logic neg);
    logic signed [35:0] sv;
    logic signed [35:0] sc;
    logic signed [35:0] s;
    sv = 36'(v);
    sc = $signed({2'b00, c});
    s  = neg ? (sv - sc) : (sv + sc);
    if (s > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -36'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

endpackage

[design/planar_nbody_gravity_step_unit.sv]
// ----------------------------------------------------------------------------
// planar_nbody_gravity_step_unit
// Softened 2D n-body stepper, Q16.16, symplectic Euler, body state in RAM.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Carries
// in      | in        | in_valid_i / in_ready_o | func, body_index, load data, dt
// out     | out       | out_valid_o/out_ready_i | one body state per item, last
// cfg     | in        | cfg_valid_i/cfg_ready_o | register index and data
//
// A step runs over the n*(n-1) ordered pairs of bodies, then reports each body.
// Each non-coincident pair runs the root unit once and one shared radix-2 divider
// three times (x and y unit vector, then acceleration); a coincident pair skips both.
// Reset clears control and the registers; body RAM is not cleared.
// A stalled output holds the reporting phase; input is taken only when idle.
module planar_nbody_gravity_step_unit #(
  parameter int unsigned MAX_BODIES = pnbg_pkg::MaxBodiesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [5:0]         body_index_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  input  logic [23:0]        in_mass_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         out_index_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic               last_o
);
  import pnbg_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BODIES);

  state_e state_q, state_d;

  logic [6:0]  active_count_q;
  logic [23:0] grav_const_q;
  logic [15:0] softening_sq_q;

  logic [6:0]  n_q, i_q, j_q;
  logic [15:0] dt_q;
  logic        out_valid_q;

  // body RAM
  body_t       mem [MAX_BODIES];
  body_t       rd_q;
  logic        mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  body_t       mem_wdata;

  // pair datapath
  body_t       bi_q;
  logic [23:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [23:0] mj_q;
  logic [47:0] sqx_q, sqy_q, k_q;
  logic [48:0] m2_q, m2_sum;
  logic [24:0] mg_q;
  logic [16:0] ux_q, uy_q;
  logic [47:0] acc_q;
  logic [63:0] prod_q;
  logic [33:0] dv_q, cx_q, cy_q;
  logic [47:0] pxm_q, pym_q;

  // root unit
  logic [49:0] sq_v_q, sq_res_q, sq_bit_q, sq_sum, sq_v_d, sq_res_d;
  logic        sq_ge;
  logic [4:0]  sq_cnt_q;

  // divider
  logic [49:0] div_rem_q, div_den_q, div_rem_d;
  logic [63:0] div_num_q, div_quo_q, div_quo_d;
  logic [50:0] div_t, div_sub;
  logic        div_ge;
  logic [6:0]  div_cnt_q;

  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic        in_fire, out_slot, adv_fire;
  logic [31:0] avx, avy;
  logic [49:0] den_acc;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_slot    = !out_valid_q || out_ready_i;
  assign adv_fire    = (state_q == ST_ADV_OUT) && out_slot;

  // ---------------------------------------------------------------- arithmetic
  assign dx  = 33'(rd_q.px) - 33'(bi_q.px);
  assign dy  = 33'(rd_q.py) - 33'(bi_q.py);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign m2_sum = 49'(sqx_q) + 49'(sqy_q);

  assign sq_sum   = sq_res_q + sq_bit_q;
  assign sq_ge    = sq_v_q >= sq_sum;
  assign sq_v_d   = sq_ge ? (sq_v_q - sq_sum) : sq_v_q;
  assign sq_res_d = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  assign div_t     = {div_rem_q, div_num_q[63]};
  assign div_sub   = div_t - {1'b0, div_den_q};
  assign div_ge    = div_t >= {1'b0, div_den_q};
  assign div_rem_d = div_ge ? div_sub[49:0] : div_t[49:0];
  assign div_quo_d = {div_quo_q[62:0], div_ge};

  assign den_acc = 50'(m2_q) + 50'({softening_sq_q, 16'h0000});
  assign avx     = bi_q.vx[31] ? 32'(-bi_q.vx) : 32'(bi_q.vx);
  assign avy     = bi_q.vy[31] ? 32'(-bi_q.vy) : 32'(bi_q.vy);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire && func_i == FUNC_STEP) state_d = ST_ROW_RD;
      ST_ROW_RD:   state_d = (i_q == n_q) ? ST_ADV_RD : ST_ROW_LAT;
      ST_ROW_LAT:  state_d = ST_PAIR_RD;
      ST_PAIR_RD: begin
        if (j_q == n_q) state_d = ST_ROW_WR;
        else if (j_q != i_q) state_d = ST_PAIR_LAT;
      end
      ST_PAIR_LAT: state_d = ST_SQR;
      ST_SQR:      state_d = ST_M2;
      ST_M2:       state_d = (m2_sum == '0) ? ST_PAIR_RD : ST_SQRT;
      ST_SQRT:     if (sq_cnt_q == 5'd1) state_d = ST_DIVX;
      ST_DIVX:     if (div_cnt_q == 7'd1) state_d = ST_DIVY;
      ST_DIVY:     if (div_cnt_q == 7'd1) state_d = ST_DIVA;
      ST_DIVA:     if (div_cnt_q == 7'd1) state_d = ST_DV_MUL;
      ST_DV_MUL:   state_d = ST_DV_CAP;
      ST_DV_CAP:   state_d = ST_U_MUL;
      ST_U_MUL:    state_d = ST_APPLY;
      ST_APPLY:    state_d = ST_PAIR_RD;
      ST_ROW_WR:   state_d = ST_ROW_RD;
      ST_ADV_RD:   state_d = (i_q == n_q) ? ST_IDLE : ST_ADV_LAT;
      ST_ADV_LAT:  state_d = ST_ADV_MUL;
      ST_ADV_MUL:  state_d = ST_ADV_OUT;
      ST_ADV_OUT:  if (out_slot) state_d = ST_ADV_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- controls
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    mem_re     = 1'b0;
    mem_raddr  = i_q[IW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = i_q[IW-1:0];
    mem_wdata  = bi_q;
    case (state_q)
      ST_IDLE: begin
        mem_we    = in_fire && func_i == FUNC_LOAD && {1'b0, body_index_i} < 7'(MAX_BODIES);
        mem_waddr = body_index_i[IW-1:0];
        mem_wdata = '{px: in_pos_x_i, py: in_pos_y_i, vx: in_vel_x_i, vy: in_vel_y_i,
                      mass: in_mass_i};
      end
      ST_ROW_RD, ST_ADV_RD: mem_re = (i_q != n_q);
      ST_PAIR_RD: begin
        mem_re    = (j_q != n_q) && (j_q != i_q);
        mem_raddr = j_q[IW-1:0];
      end
      ST_ROW_WR:  mem_we = 1'b1;
      ST_ADV_OUT: begin
        mem_we       = out_slot;
        mem_wdata.px = sat_add(bi_q.px, {2'b00, pxm_q[47:16]}, bi_q.vx[31]);
        mem_wdata.py = sat_add(bi_q.py, {2'b00, pym_q[47:16]}, bi_q.vy[31]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_count_q <= ActiveCountRst;
      grav_const_q   <= GravConstRst;
      softening_sq_q <= SofteningRst;
      n_q            <= '0;
      i_q            <= '0;
      j_q            <= '0;
      dt_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ACTIVE_COUNT: active_count_q <= cfg_data_i[6:0];
          CFG_GRAV_CONST:   grav_const_q   <= cfg_data_i;
          CFG_SOFTENING_SQ: softening_sq_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (adv_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire && func_i == FUNC_STEP) begin
            n_q  <= (active_count_q > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : active_count_q;
            dt_q <= time_step_i;
            i_q  <= '0;
          end
        end
        ST_ROW_RD:  if (i_q == n_q) i_q <= '0;
        ST_ROW_LAT: j_q <= '0;
        ST_PAIR_RD: if (j_q != n_q && j_q == i_q) j_q <= j_q + 7'd1;
        ST_M2:      if (m2_sum == '0) j_q <= j_q + 7'd1;
        ST_APPLY:   j_q <= j_q + 7'd1;
        ST_ROW_WR:  i_q <= i_q + 7'd1;
        ST_ADV_OUT: if (out_slot) i_q <= i_q + 7'd1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ROW_LAT, ST_ADV_LAT: bi_q <= rd_q;
      ST_PAIR_LAT: begin
        ax_q   <= adx[31:8];
        ay_q   <= ady[31:8];
        negx_q <= dx[32];
        negy_q <= dy[32];
        mj_q   <= rd_q.mass;
      end
      ST_SQR: begin
        sqx_q <= 48'(ax_q) * 48'(ax_q);
        sqy_q <= 48'(ay_q) * 48'(ay_q);
        k_q   <= 48'(grav_const_q) * 48'(mj_q);
      end
      ST_M2: begin
        m2_q     <= m2_sum;
        sq_v_q   <= 50'(m2_sum);
        sq_res_q <= '0;
        sq_bit_q <= 50'(1) << 48;
        sq_cnt_q <= 5'd25;
      end
      ST_SQRT: begin
        sq_v_q   <= sq_v_d;
        sq_res_q <= sq_res_d;
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q - 5'd1;
        if (sq_cnt_q == 5'd1) begin
          mg_q      <= sq_res_d[24:0];
          div_den_q <= {25'd0, sq_res_d[24:0]};
          div_num_q <= {ax_q, 40'd0};
          div_rem_q <= '0;
          div_quo_q <= '0;
          div_cnt_q <= 7'd40;
        end
      end
      ST_DIVX, ST_DIVY, ST_DIVA: begin
        if (div_cnt_q == 7'd1) begin
          div_rem_q <= '0;
          div_quo_q <= '0;
          if (state_q == ST_DIVX) begin
            ux_q      <= div_quo_d[16:0];
            div_den_q <= {25'd0, mg_q};
            div_num_q <= {ay_q, 40'd0};
            div_cnt_q <= 7'd40;
          end else if (state_q == ST_DIVY) begin
            uy_q      <= div_quo_d[16:0];
            div_den_q <= den_acc;
            div_num_q <= {k_q, 16'h0000};
            div_cnt_q <= 7'd64;
          end else begin
            acc_q <= (div_quo_d[63:48] != '0) ? AccCap : div_quo_d[47:0];
          end
        end else begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_num_q <= {div_num_q[62:0], 1'b0};
          div_cnt_q <= div_cnt_q - 7'd1;
        end
      end
      ST_DV_MUL: prod_q <= 64'(acc_q) * 64'(dt_q);
      ST_DV_CAP: dv_q <= (prod_q[63:16] > 48'(DvCap)) ? DvCap : prod_q[49:16];
      ST_U_MUL: begin
        cx_q <= 34'((51'(dv_q) * 51'(ux_q)) >> 16);
        cy_q <= 34'((51'(dv_q) * 51'(uy_q)) >> 16);
      end
      ST_APPLY: begin
        bi_q.vx <= sat_add(bi_q.vx, cx_q, negx_q);
        bi_q.vy <= sat_add(bi_q.vy, cy_q, negy_q);
      end
      ST_ADV_MUL: begin
        pxm_q <= 48'(avx) * 48'(dt_q);
        pym_q <= 48'(avy) * 48'(dt_q);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output item
  logic [5:0]         out_index_q;
  logic signed [31:0] out_pos_x_q, out_pos_y_q, out_vel_x_q, out_vel_y_q;
  logic               last_q;

  always_ff @(posedge clk_i) begin
    if (adv_fire) begin
      out_index_q <= i_q[5:0];
      out_pos_x_q <= mem_wdata.px;
      out_pos_y_q <= mem_wdata.py;
      out_vel_x_q <= bi_q.vx;
      out_vel_y_q <= bi_q.vy;
      last_q      <= (i_q + 7'd1 == n_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_pos_x_o = out_pos_x_q;
  assign out_pos_y_o = out_pos_y_q;
  assign out_vel_x_o = out_vel_x_q;
  assign out_vel_y_o = out_vel_y_q;
  assign last_o      = last_q;

  // ---------------------------------------------------------------- checks
  a_no_self_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAIR_LAT |-> j_q != i_q)
    else $error("pair stage holds a body against itself");

  a_no_write_in_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAIR_RD || state_q == ST_PAIR_LAT || state_q == ST_APPLY) |-> !mem_we)
    else $error("body RAM written during the pair phase");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIVY |-> mg_q != '0)
    else $error("zero divisor reached the unit-vector divide");

  a_out_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == ST_ADV_OUT) |=> state_q == ST_ADV_OUT)
    else $error("report advanced over a stalled output");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Bench for planar_nbody_gravity_step_unit: loads bodies, runs time steps
// under several register settings, and predicts every reported body state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pnbg_pkg::*;

  localparam logic [1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned NumBodies = MaxBodiesDef;
  localparam longint unsigned CycleLimit = 20_000_000;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               last;
  } body_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               func_i = FUNC_LOAD;
  logic [5:0]         body_index_i = '0;
  logic signed [31:0] in_pos_x_i = '0;
  logic signed [31:0] in_pos_y_i = '0;
  logic signed [31:0] in_vel_x_i = '0;
  logic signed [31:0] in_vel_y_i = '0;
  logic [23:0]        in_mass_i = '0;
  logic [15:0]        time_step_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [5:0]         out_index_o;
  logic signed [31:0] out_pos_x_o;
  logic signed [31:0] out_pos_y_o;
  logic signed [31:0] out_vel_x_o;
  logic signed [31:0] out_vel_y_o;
  logic               last_o;

  planar_nbody_gravity_step_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predicted body store and registers
  longint          sim_px[NumBodies];
  longint          sim_py[NumBodies];
  longint          sim_vx[NumBodies];
  longint          sim_vy[NumBodies];
  longint unsigned sim_mass[NumBodies];
  longint unsigned reg_active = ActiveCountRst;
  longint unsigned reg_grav   = GravConstRst;
  longint unsigned reg_soft   = SofteningRst;

  body_report_t pending_reports[$];
  int           mismatches = 0;
  longint unsigned cycles = 0;
  int           burst_left = 0;
  logic [15:0]  ready_pattern = 16'hFFFF;
  int           pattern_age = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint signed_nudge(longint v, longint unsigned c, logic neg);
    return clip32(neg ? v - longint'(c) : v + longint'(c));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // velocity change of body i due to body j
  task automatic gravity_pull(int i, int j, longint unsigned dt);
    longint dx, dy;
    longint unsigned ax, ay, m2, mg, ux, uy, den, k, acc, dv;
    dx = sim_px[j] - sim_px[i];
    dy = sim_py[j] - sim_py[i];
    ax = longint'(dx < 0 ? -dx : dx) >> 8;
    ay = longint'(dy < 0 ? -dy : dy) >> 8;
    m2 = ax * ax + ay * ay;
    if (m2 == 0) return;
    mg  = int_sqrt(m2);
    ux  = (ax << 16) / mg;
    uy  = (ay << 16) / mg;
    den = m2 + (reg_soft << 16);
    k   = reg_grav * sim_mass[j];
    if (k / den >= (64'd1 << 32)) acc = 64'(AccCap);
    else acc = (k << 16) / den;
    dv = (acc * dt) >> 16;
    if (dv > 64'(DvCap)) dv = 64'(DvCap);
    sim_vx[i] = signed_nudge(sim_vx[i], (dv * ux) >> 16, dx < 0);
    sim_vy[i] = signed_nudge(sim_vy[i], (dv * uy) >> 16, dy < 0);
  endtask

  task automatic predict_step(longint unsigned dt);
    int n;
    body_report_t r;
    n = (reg_active > NumBodies) ? NumBodies : int'(reg_active);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j) gravity_pull(i, j, dt);
    for (int i = 0; i < n; i++) begin
      sim_px[i] = signed_nudge(sim_px[i], (longint'(sim_vx[i] < 0 ? -sim_vx[i] : sim_vx[i])
                                * dt) >> 16, sim_vx[i] < 0);
      sim_py[i] = signed_nudge(sim_py[i], (longint'(sim_vy[i] < 0 ? -sim_vy[i] : sim_vy[i])
                                * dt) >> 16, sim_vy[i] < 0);
      r.index = 6'(i);
      r.pos_x = 32'(sim_px[i]);
      r.pos_y = 32'(sim_py[i]);
      r.vel_x = 32'(sim_vx[i]);
      r.vel_y = 32'(sim_vy[i]);
      r.last  = (i == n - 1);
      pending_reports.insert(pending_reports.size(), r);
    end
  endtask

  // sender: bursts of items with random gaps in between
  task automatic send_item(func_e f, logic [5:0] idx, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] vx,
                           logic signed [31:0] vy, logic [23:0] m, logic [15:0] dt);
    int gap;
    func_i       <= f;
    body_index_i <= idx;
    in_pos_x_i   <= px;
    in_pos_y_i   <= py;
    in_vel_x_i   <= vx;
    in_vel_y_i   <= vy;
    in_mass_i    <= m;
    time_step_i  <= dt;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (f == FUNC_LOAD) begin
      sim_px[idx]   = px;
      sim_py[idx]   = py;
      sim_vx[idx]   = vx;
      sim_vy[idx]   = vy;
      sim_mass[idx] = m;
    end else begin
      predict_step(dt);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_body(int idx, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] vx, logic signed [31:0] vy, logic [23:0] m);
    send_item(FUNC_LOAD, 6'(idx), px, py, vx, vy, m, 16'($urandom));
  endtask

  task automatic step_bodies(logic [15:0] dt);
    send_item(FUNC_STEP, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
              24'($urandom), dt);
  endtask

  // wait until every predicted report has arrived and the block has settled
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    settle();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ACTIVE_COUNT: reg_active = data & 24'h7F;
      CFG_GRAV_CONST:   reg_grav   = data;
      CFG_SOFTENING_SQ: reg_soft   = data & 24'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(bit clustered);
    if (clustered) return $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
    return $urandom;
  endfunction

  task automatic test_directed();
    step_bodies(16'hFFFF);  // no active bodies: nothing reported
    load_body(0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 24'hFF_FFFF);
    load_body(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'h0);
    load_body(2, 32'sh80, 32'sh7F, 32'sh0, 32'sh0, 24'd5);  // coincident with body 0
    load_body(3, 32'sh000A_0000, -32'sh0014_0000, 32'sh0001_8000, -32'sh0000_4000, 24'd1000);
    write_reg(CFG_ACTIVE_COUNT, 24'd4);
    step_bodies(16'hFFFF);
    step_bodies(16'h0000);
    step_bodies(16'h0800);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_GRAV_CONST, 24'hFF_FFFF);
    write_reg(CFG_SOFTENING_SQ, 24'h0);
    step_bodies(16'h1000);
    write_reg(CFG_GRAV_CONST, 24'h0);
    write_reg(CFG_SOFTENING_SQ, 24'h00_FFFF);
    step_bodies(16'h4000);
    write_reg(CFG_ACTIVE_COUNT, 24'hFF_FF82);  // upper bits dropped: 2 bodies
    write_reg(CfgIdxUnused, 24'hFF_FFFF);
    step_bodies(16'h2000);
  endtask

  task automatic test_random();
    bit cl;
    for (int i = 0; i < NumBodies; i++) begin
      cl = ($urandom_range(0, 3) != 0);
      load_body(i, rand_coord(cl), rand_coord(cl), rand_coord(cl), rand_coord(cl),
                24'($urandom));
    end
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_ACTIVE_COUNT, {17'($urandom), 7'($urandom_range(2, 7))});
      write_reg(CFG_GRAV_CONST, 24'($urandom));
      write_reg(CFG_SOFTENING_SQ, 24'($urandom));
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          step_bodies(16'($urandom));
        end else begin
          cl = $urandom_range(0, 1);
          load_body($urandom_range(0, NumBodies - 1), rand_coord(cl), rand_coord(cl),
                    rand_coord(cl), rand_coord(cl), 24'($urandom));
        end
      end
    end
  endtask

  task automatic test_full_set();
    write_reg(CFG_ACTIVE_COUNT, 24'd100);  // clamps to all bodies
    step_bodies(16'h0100);
    write_reg(CFG_ACTIVE_COUNT, 24'd127);
    write_reg(CFG_ACTIVE_COUNT, 24'd3);
    step_bodies(16'h8000);
  endtask

  initial begin
    for (int i = 0; i < NumBodies; i++) begin
      sim_px[i] = 0; sim_py[i] = 0; sim_vx[i] = 0; sim_vy[i] = 0; sim_mass[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random();
    test_full_set();
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // receiver stalls on a rotating pattern, reloaded now and then
  always @(posedge clk_i) begin
    if (pattern_age == 63) begin
      pattern_age <= 0;
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
    end else begin
      pattern_age <= pattern_age + 1;
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    end
    out_ready_i <= ready_pattern[15];
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    body_report_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report for body %0d", out_index_o);
        mismatches++;
      end else begin
        r = pending_reports.pop_front();
        check_field("out_index", r.index, out_index_o);
        check_field("out_pos_x", r.pos_x, out_pos_x_o);
        check_field("out_pos_y", r.pos_y, out_pos_y_o);
        check_field("out_vel_x", r.vel_x, out_vel_x_o);
        check_field("out_vel_y", r.vel_y, out_vel_y_o);
        check_field("last", r.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
